[hdl/ecv_pkg.sv]
// shared types, constants, sine table and step program of the ellipse contour visibility unit
`default_nettype none

package ecv_pkg;

	localparam int MAX_POINTS = 36;
	localparam int OPD_W      = 25;
	localparam int ACC_W      = 76;
	localparam int STEP_W     = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(23);

	typedef enum logic [1:0] {
		REG_SENSOR_X = 2'd0,
		REG_SENSOR_Y = 2'd1,
		REG_MAJOR    = 2'd2,
		REG_MINOR    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MAC_HOLD = 2'd0,
		MAC_LOAD = 2'd1,
		MAC_ADD  = 2'd2,
		MAC_SUB  = 2'd3
	} mac_op_t;

	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_19 = 2'd1,
		SH_24 = 2'd2,
		SH_36 = 2'd3
	} shift_t;

	typedef enum logic [4:0] {
		OPD_NONE, OPD_MINOR, OPD_MAJOR, OPD_M2, OPD_J2, OPD_PX, OPD_PY, OPD_C, OPD_S,
		OPD_NX, OPD_NY, OPD_VX, OPD_VY, OPD_DX, OPD_DY, OPD_DH, OPD_DL, OPD_DH25,
		OPD_DL25, OPD_DD, OPD_NNL, OPD_NNH
	} opnd_t;

	typedef enum logic [3:0] {
		CAP_NONE, CAP_M2, CAP_J2, CAP_NX, CAP_NY, CAP_POSX, CAP_POSY, CAP_VX, CAP_VY,
		CAP_DOT, CAP_DD, CAP_NN, CAP_LHS, CAP_VIS
	} cap_t;

	typedef struct packed {
		mac_op_t op;
		shift_t  sh;
	} mac_ctl_t;

	typedef struct packed {
		mac_op_t op;
		shift_t  sh;
		opnd_t   a_sel;
		opnd_t   b_sel;
		cap_t    cap;
	} ucode_t;

	typedef struct packed {
		logic              ready;
		logic              accept;
		logic              run;
		logic [STEP_W-1:0] step;
		logic              load_out;
	} seq_t;

	localparam logic [15:0] SIN_ROM [91] = '{
		16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
		16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
		16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
		16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
		16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795, 16'd19261,
		16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926, 16'd22348,
		16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102,
		16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
		16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
		16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
		16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928, 16'd32052,
		16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588, 16'd32643,
		16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
	};

	// q15 sine of a whole degree in 0..359
	function automatic logic signed [16:0] sin_deg(input logic [8:0] q);
		logic [8:0]         i;
		logic               neg;
		logic signed [16:0] mag;
		if (q <= 9'd90) begin
			i   = q;
			neg = 1'b0;
		end else if (q <= 9'd180) begin
			i   = 9'd180 - q;
			neg = 1'b0;
		end else if (q <= 9'd270) begin
			i   = q - 9'd180;
			neg = 1'b1;
		end else begin
			i   = 9'd360 - q;
			neg = 1'b1;
		end
		mag = signed'({1'b0, SIN_ROM[i[6:0]]});
		return neg ? -mag : mag;
	endfunction

	// step program of the shared multiplier
	function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
		ucode_t u;
		case (step)
			5'd0:  u = '{MAC_LOAD, SH_0,  OPD_MINOR, OPD_MINOR, CAP_NONE};
			5'd1:  u = '{MAC_LOAD, SH_0,  OPD_MAJOR, OPD_MAJOR, CAP_M2};
			5'd2:  u = '{MAC_LOAD, SH_0,  OPD_M2,    OPD_PX,    CAP_J2};
			5'd3:  u = '{MAC_LOAD, SH_0,  OPD_J2,    OPD_PY,    CAP_NX};
			5'd4:  u = '{MAC_LOAD, SH_0,  OPD_C,     OPD_PX,    CAP_NY};
			5'd5:  u = '{MAC_SUB,  SH_0,  OPD_S,     OPD_PY,    CAP_NONE};
			5'd6:  u = '{MAC_LOAD, SH_0,  OPD_S,     OPD_PX,    CAP_POSX};
			5'd7:  u = '{MAC_ADD,  SH_0,  OPD_C,     OPD_PY,    CAP_NONE};
			5'd8:  u = '{MAC_LOAD, SH_0,  OPD_C,     OPD_NX,    CAP_POSY};
			5'd9:  u = '{MAC_SUB,  SH_0,  OPD_S,     OPD_NY,    CAP_NONE};
			5'd10: u = '{MAC_LOAD, SH_0,  OPD_S,     OPD_NX,    CAP_VX};
			5'd11: u = '{MAC_ADD,  SH_0,  OPD_C,     OPD_NY,    CAP_NONE};
			5'd12: u = '{MAC_LOAD, SH_0,  OPD_VX,    OPD_DX,    CAP_VY};
			5'd13: u = '{MAC_ADD,  SH_0,  OPD_VY,    OPD_DY,    CAP_NONE};
			5'd14: u = '{MAC_LOAD, SH_0,  OPD_DX,    OPD_DX,    CAP_DOT};
			5'd15: u = '{MAC_ADD,  SH_0,  OPD_DY,    OPD_DY,    CAP_NONE};
			5'd16: u = '{MAC_LOAD, SH_0,  OPD_VX,    OPD_VX,    CAP_DD};
			5'd17: u = '{MAC_ADD,  SH_0,  OPD_VY,    OPD_VY,    CAP_NONE};
			5'd18: u = '{MAC_LOAD, SH_36, OPD_DH,    OPD_DH25,  CAP_NN};
			5'd19: u = '{MAC_ADD,  SH_19, OPD_DH,    OPD_DL25,  CAP_NONE};
			5'd20: u = '{MAC_ADD,  SH_0,  OPD_DL,    OPD_DL25,  CAP_NONE};
			5'd21: u = '{MAC_LOAD, SH_0,  OPD_DD,    OPD_NNL,   CAP_LHS};
			5'd22: u = '{MAC_ADD,  SH_24, OPD_DD,    OPD_NNH,   CAP_NONE};
			5'd23: u = '{MAC_HOLD, SH_0,  OPD_NONE,  OPD_NONE,  CAP_VIS};
			default: u = '{MAC_HOLD, SH_0, OPD_NONE, OPD_NONE, CAP_NONE};
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

[hdl/ecv_mac.sv]
// shared signed multiplier with shifted accumulate
`default_nettype none

module ecv_mac (
	input  wire logic                                clk,
	input  wire ecv_pkg::mac_ctl_t                   ctl,
	input  wire logic signed [ecv_pkg::OPD_W-1:0]    a,
	input  wire logic signed [ecv_pkg::OPD_W-1:0]    b,
	output logic signed [ecv_pkg::ACC_W-1:0]         acc
);
	import ecv_pkg::*;

	localparam int PROD_W = 2 * OPD_W;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  acc_q;

	assign prod     = a * b;
	assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

	always_comb begin
		case (ctl.sh)
			SH_0:    term = prod_ext;
			SH_19:   term = prod_ext <<< 19;
			SH_24:   term = prod_ext <<< 24;
			SH_36:   term = prod_ext <<< 36;
			default: term = prod_ext;
		endcase
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			MAC_LOAD: acc_q <= term;
			MAC_ADD:  acc_q <= acc_q + term;
			MAC_SUB:  acc_q <= acc_q - term;
			default:  acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

[hdl/ecv_ctrl.sv]
// step sequencer and handshake control
`default_nettype none

module ecv_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          out_free,
	output ecv_pkg::seq_t      seq
);
	import ecv_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		seq.ready    = (state_q == ST_IDLE);
		seq.accept   = (state_q == ST_IDLE) && in_valid;
		seq.run      = (state_q == ST_RUN);
		seq.step     = step_q;
		seq.load_out = (state_q == ST_FIN) && out_free;
	end

endmodule

`default_nettype wire

[hdl/ellipse_contour_visibility_unit.sv]
// top level: ellipse contour point placement and visibility test
// usage:
//   s_* stream: one contour point word with pose, s_tlast marks the last point of a pose
//   m_* stream: one result word per point, m_tlast copies the input's last flag
//   cfg_we/cfg_index/cfg_data: sensor position and semi-axes, write only while idle
// timing:
//   m_tvalid rises once all steps have run and the result is placed in the output register
//   one point at a time, its 24 steps run on the single shared
//   25x25 multiplier-accumulator (rotation, normal, dot product, squared compare)
//   s_tready is low from accept until the result is placed in the output register
//   the output register frees the core, so the next word is taken while a
//   result still waits on m_tready
// stall: a stalled result holds; a finished point waits for the output
//   register to drain before it is written
// reset: arst_n clears control, the visible count, sensor (0,0) and both axes to 1
`default_nettype none

module ellipse_contour_visibility_unit #(
	parameter int MAX_POINTS = ecv_pkg::MAX_POINTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // point_x, point_y, center_x, center_y, rotation_deg
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // pos_x, pos_y, visible, visible_count
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);
	import ecv_pkg::*;

	seq_t                      seq;
	ucode_t                    uc;
	mac_ctl_t                  mac_ctl;
	logic signed [OPD_W-1:0]   opd_a;
	logic signed [OPD_W-1:0]   opd_b;
	logic signed [ACC_W-1:0]   acc;

	logic [9:0]          sensor_x_q, sensor_y_q;
	logic [6:0]          major_q, minor_q;

	logic signed [7:0]   px_q, py_q;
	logic [9:0]          cx_q, cy_q;
	logic                last_q;
	logic signed [16:0]  c_q, s_q;
	logic [13:0]         m2_q, j2_q;
	logic signed [21:0]  nx_q, ny_q;
	logic signed [11:0]  posx_q, posy_q;
	logic signed [23:0]  vx_q, vy_q;
	logic signed [35:0]  dot_q;
	logic [21:0]         dd_q;
	logic [46:0]         nn_q;
	logic [71:0]         lhs_q;
	logic                vis_q;
	logic [6:0]          cnt_q;

	logic                m_valid_q;
	logic [31:0]         m_data_q;
	logic                m_last_q;

	logic [8:0]          rot_in, rot_red, rot_cos;
	logic signed [12:0]  dx, dy;
	logic [15:0]         dh;
	logic [17:0]         dl;
	logic [20:0]         dh25;
	logic [22:0]         dl25;
	logic signed [23:0]  rnd;
	logic [6:0]          cnt_next;
	logic                out_free;

	assign out_free = !m_valid_q || m_tready;

	ecv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.seq      (seq)
	);

	assign uc          = ucode(seq.step);
	assign mac_ctl.op  = seq.run ? uc.op : MAC_HOLD;
	assign mac_ctl.sh  = uc.sh;

	ecv_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (opd_a),
		.b   (opd_b),
		.acc (acc)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_x_q <= '0;
			sensor_y_q <= '0;
			major_q    <= 7'd1;
			minor_q    <= 7'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSOR_X: sensor_x_q <= cfg_data;
				REG_SENSOR_Y: sensor_y_q <= cfg_data;
				REG_MAJOR:    major_q    <= cfg_data[6:0];
				REG_MINOR:    minor_q    <= cfg_data[6:0];
				default:      ;
			endcase
		end
	end

	// angle reduction and sine/cosine lookup at accept
	assign rot_in  = s_tdata[44:36];
	assign rot_red = (rot_in >= 9'd360) ? rot_in - 9'd360 : rot_in;
	assign rot_cos = (rot_red >= 9'd270) ? rot_red - 9'd270 : rot_red + 9'd90;

	always_ff @(posedge clk) begin
		if (seq.accept) begin
			px_q   <= signed'(s_tdata[7:0]);
			py_q   <= signed'(s_tdata[15:8]);
			cx_q   <= s_tdata[25:16];
			cy_q   <= s_tdata[35:26];
			last_q <= s_tlast;
			s_q    <= sin_deg(rot_red);
			c_q    <= sin_deg(rot_cos);
		end
	end

	// derived operands
	assign dx   = signed'({3'b000, sensor_x_q}) - 13'(posx_q);
	assign dy   = signed'({3'b000, sensor_y_q}) - 13'(posy_q);
	assign dh   = dot_q[33:18];
	assign dl   = dot_q[17:0];
	assign dh25 = {1'b0, dh, 4'b0000} + {2'b00, dh, 3'b000} + {5'b00000, dh};
	assign dl25 = {1'b0, dl, 4'b0000} + {2'b00, dl, 3'b000} + {5'b00000, dl};

	function automatic logic signed [OPD_W-1:0] opnd(input opnd_t sel);
		logic signed [OPD_W-1:0] v;
		case (sel)
			OPD_MINOR: v = signed'({18'd0, minor_q});
			OPD_MAJOR: v = signed'({18'd0, major_q});
			OPD_M2:    v = signed'({11'd0, m2_q});
			OPD_J2:    v = signed'({11'd0, j2_q});
			OPD_PX:    v = {{17{px_q[7]}}, px_q};
			OPD_PY:    v = {{17{py_q[7]}}, py_q};
			OPD_C:     v = {{8{c_q[16]}}, c_q};
			OPD_S:     v = {{8{s_q[16]}}, s_q};
			OPD_NX:    v = {{3{nx_q[21]}}, nx_q};
			OPD_NY:    v = {{3{ny_q[21]}}, ny_q};
			OPD_VX:    v = {vx_q[23], vx_q};
			OPD_VY:    v = {vy_q[23], vy_q};
			OPD_DX:    v = {{12{dx[12]}}, dx};
			OPD_DY:    v = {{12{dy[12]}}, dy};
			OPD_DH:    v = signed'({9'd0, dh});
			OPD_DL:    v = signed'({7'd0, dl});
			OPD_DH25:  v = signed'({4'd0, dh25});
			OPD_DL25:  v = signed'({2'd0, dl25});
			OPD_DD:    v = signed'({3'd0, dd_q});
			OPD_NNL:   v = signed'({1'b0, nn_q[23:0]});
			OPD_NNH:   v = signed'({2'd0, nn_q[46:24]});
			default:   v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opd_a = opnd(uc.a_sel);
		opd_b = opnd(uc.b_sel);
	end

	// q15 round to nearest, ties up
	function automatic logic signed [23:0] rnd24(input logic signed [ACC_W-1:0] v);
		logic [39:0] t;
		t = v[39:0] + 40'd16384;
		return signed'(t[38:15]);
	endfunction

	assign rnd = rnd24(acc);

	// capture of the previous step's accumulator
	always_ff @(posedge clk) begin
		if (seq.run) begin
			case (uc.cap)
				CAP_M2:   m2_q   <= acc[13:0];
				CAP_J2:   j2_q   <= acc[13:0];
				CAP_NX:   nx_q   <= acc[21:0];
				CAP_NY:   ny_q   <= acc[21:0];
				CAP_POSX: posx_q <= rnd[11:0] + signed'({2'b00, cx_q});
				CAP_POSY: posy_q <= rnd[11:0] + signed'({2'b00, cy_q});
				CAP_VX:   vx_q   <= rnd;
				CAP_VY:   vy_q   <= rnd;
				CAP_DOT:  dot_q  <= acc[35:0];
				CAP_DD:   dd_q   <= acc[21:0];
				CAP_NN:   nn_q   <= acc[46:0];
				CAP_LHS:  lhs_q  <= acc[71:0];
				CAP_VIS:  vis_q  <= (dot_q > 36'sd0) && (lhs_q > acc[71:0]);
				default:  ;
			endcase
		end
	end

	// visible count and output register
	assign cnt_next = (vis_q && (cnt_q < 7'(MAX_POINTS))) ? cnt_q + 7'd1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (seq.load_out) begin
				cnt_q     <= last_q ? 7'd0 : cnt_next;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq.load_out) begin
			m_data_q <= {cnt_next, vis_q, posy_q, posx_q};
			m_last_q <= last_q;
		end
	end

	assign s_tready = seq.ready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	// checks
	assert property (@(posedge clk) disable iff (!arst_n) seq.run |-> !s_tready)
		else $error("input taken while a point is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_data_q[31:25] <= 7'(MAX_POINTS)))
		else $error("visible count above limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[24] |-> (m_data_q[31:25] != 7'd0))
		else $error("visible point with zero count");

	assert property (@(posedge clk) disable iff (!arst_n)
		seq.load_out && last_q |=> (cnt_q == 7'd0))
		else $error("count not cleared after last point");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for the ellipse contour visibility unit
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ecv_pkg::*;

	localparam int COUNT_CAP  = 36;
	localparam int STALL_MAX  = 3000;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 500;
	localparam int DRAIN_WAIT = 40;

	typedef struct {
		logic signed [7:0] px;
		logic signed [7:0] py;
		logic [9:0]        cx;
		logic [9:0]        cy;
		logic [8:0]        rot;
		logic              last;
	} point_t;

	typedef struct {
		logic [11:0] x;
		logic [11:0] y;
		logic        vis;
		logic [6:0]  cnt;
		logic        last;
	} placed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	cfg_reg_t    cfg_index = REG_SENSOR_X;
	logic [9:0]  cfg_data = '0;

	point_t  pending_pts[$];
	placed_t placed_due[$];
	point_t  cur_pt;

	logic [9:0] sns_x = 10'd0;
	logic [9:0] sns_y = 10'd0;
	logic [6:0] axis_major = 7'd1;
	logic [6:0] axis_minor = 7'd1;
	logic [6:0] vis_tally = 7'd0;

	int  errors = 0;
	int  words_seen = 0;
	bit  gaps_on = 1'b1;

	ellipse_contour_visibility_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint q15_sin(input int unsigned deg);
		int unsigned idx;
		bit          neg;
		longint      mag;
		if (deg <= 90) begin
			idx = deg;
			neg = 1'b0;
		end else if (deg <= 180) begin
			idx = 180 - deg;
			neg = 1'b0;
		end else if (deg <= 270) begin
			idx = deg - 180;
			neg = 1'b1;
		end else begin
			idx = 360 - deg;
			neg = 1'b1;
		end
		mag = $rtoi($floor(32768.0 * $sin(idx * 3.1415926535897932 / 180.0) + 0.5));
		return neg ? -mag : mag;
	endfunction

	function automatic longint q15_round(input longint v);
		return (v + 64'sd16384) >>> 15;
	endfunction

	// rotate, translate, test the normal against the sensor, update the pose tally
	function automatic placed_t place_point(input point_t p);
		placed_t             o;
		int unsigned         deg;
		longint              s, c, px, py, nx, ny, posx, posy, vx, vy, dx, dy, dot;
		logic signed [127:0] lhs, rhs;
		deg = p.rot;
		if (deg >= 360)
			deg -= 360;
		s = q15_sin(deg);
		c = q15_sin((deg + 90) % 360);
		px = p.px;
		py = p.py;
		nx = longint'(axis_minor) * longint'(axis_minor) * px;
		ny = longint'(axis_major) * longint'(axis_major) * py;
		posx = q15_round(c * px - s * py) + longint'(p.cx);
		posy = q15_round(s * px + c * py) + longint'(p.cy);
		vx = q15_round(c * nx - s * ny);
		vy = q15_round(s * nx + c * ny);
		dx = longint'(sns_x) - posx;
		dy = longint'(sns_y) - posy;
		dot = vx * dx + vy * dy;
		o.vis = 1'b0;
		if (dot > 0) begin
			lhs = dot;
			lhs = lhs * lhs * 25;
			rhs = dx * dx + dy * dy;
			rhs = rhs * (vx * vx + vy * vy);
			o.vis = lhs > rhs;
		end
		if (o.vis && vis_tally < COUNT_CAP)
			vis_tally = vis_tally + 7'd1;
		o.x = posx[11:0];
		o.y = posy[11:0];
		o.cnt = vis_tally;
		o.last = p.last;
		if (p.last)
			vis_tally = 7'd0;
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// sender
	int src_gap = 0;
	always @(posedge clk) begin
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = s_tvalid;
			if (s_tvalid && s_tready)
				placed_due.push_back(place_point(cur_pt));
			if (!s_tvalid || s_tready) begin
				nxt_valid = 1'b0;
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending_pts.size() > 0) begin
					cur_pt = pending_pts.pop_front();
					s_tdata <= {3'b000, cur_pt.rot, cur_pt.cy, cur_pt.cx, cur_pt.py, cur_pt.px};
					s_tlast <= cur_pt.last;
					nxt_valid = 1'b1;
					src_gap = pick_gap();
				end
			end
			s_tvalid <= nxt_valid;
		end
	end

	// receiver and checker
	int  sink_gap = 0;
	int  hold_left = 0;
	bit  held = 1'b0;
	always @(posedge clk) begin
		placed_t want, got;
		logic    nxt_ready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				words_seen++;
				got.x = m_tdata[11:0];
				got.y = m_tdata[23:12];
				got.vis = m_tdata[24];
				got.cnt = m_tdata[31:25];
				got.last = m_tlast;
				if (placed_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result word with nothing expected", $realtime);
				end else begin
					want = placed_due.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.vis !== want.vis ||
					    got.cnt !== want.cnt || got.last !== want.last) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch exp x=%0d y=%0d vis=%0b cnt=%0d last=%0b",
							         $realtime, $signed(want.x), $signed(want.y), want.vis,
							         want.cnt, want.last);
							$display("    got x=%0d y=%0d vis=%0b cnt=%0d last=%0b",
							         $signed(got.x), $signed(got.y), got.vis, got.cnt,
							         got.last);
						end
					end
				end
				if (words_seen == HOLD_AT && !held) begin
					held = 1'b1;
					hold_left = HOLD_LEN;
				end
			end
			nxt_ready = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				nxt_ready = 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				nxt_ready = 1'b0;
			end else if ((m_tvalid && m_tready) || $urandom_range(0, 7) == 0) begin
				sink_gap = pick_gap();
				nxt_ready = (sink_gap == 0);
			end
			m_tready <= nxt_ready;
		end
	end

	// watchdog on cycles without any accepted word
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_MAX) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic set_reg(input cfg_reg_t idx, input logic [9:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SENSOR_X: sns_x = val;
			REG_SENSOR_Y: sns_y = val;
			REG_MAJOR:    axis_major = val[6:0];
			REG_MINOR:    axis_minor = val[6:0];
			default:      ;
		endcase
	endtask

	task automatic set_pose_config(input logic [9:0] sx, input logic [9:0] sy,
	                               input logic [6:0] maj, input logic [6:0] mnr);
		logic [2:0] junk;
		set_reg(REG_SENSOR_X, sx);
		set_reg(REG_SENSOR_Y, sy);
		junk = $urandom_range(0, 7);
		set_reg(REG_MAJOR, {junk, maj});
		junk = $urandom_range(0, 7);
		set_reg(REG_MINOR, {junk, mnr});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_pts.size() > 0 || s_tvalid || placed_due.size() > 0)
			@(posedge clk);
	endtask

	task automatic add_point(input int px, input int py, input int cx, input int cy,
	                         input int rot, input bit last);
		point_t p;
		p.px = px[7:0];
		p.py = py[7:0];
		p.cx = cx[9:0];
		p.cy = cy[9:0];
		p.rot = rot[8:0];
		p.last = last;
		pending_pts.push_back(p);
	endtask

	function automatic logic [9:0] pick_sensor();
		case ($urandom_range(0, 3))
			0: return 10'd0;
			1: return 10'd1023;
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	function automatic logic [6:0] pick_axis();
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd127;
			default: return $urandom_range(1, 127);
		endcase
	endfunction

	// whole poses with random content, a few broken last flags and odd rotations
	task automatic add_poses(input int n);
		int cnt, len, cx, cy, rot, k;
		bit lst;
		cnt = 0;
		while (cnt < n) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 64) : $urandom_range(1, 40);
			cx = $urandom_range(0, 1023);
			cy = $urandom_range(0, 1023);
			rot = ($urandom_range(0, 7) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
			for (k = 0; k < len; k++) begin
				lst = (k == len - 1) || ($urandom_range(0, 31) == 0);
				add_point($urandom_range(0, 255), $urandom_range(0, 255), cx, cy, rot, lst);
			end
			cnt += len;
		end
	endtask

	initial begin
		int ph, k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: sensor at the origin, unit axes
		add_point(0, 0, 512, 512, 0, 0);
		add_point(127, 127, 0, 0, 0, 0);
		add_point(-127, -127, 1023, 1023, 90, 0);
		add_point(127, -127, 0, 1023, 180, 0);
		add_point(-127, 127, 1023, 0, 270, 0);
		add_point(100, -50, 500, 500, 359, 0);
		add_point(100, -50, 500, 500, 360, 0);
		add_point(-128, -128, 0, 0, 511, 0);
		add_point(-5, 0, 5, 0, 0, 0);
		add_point(-100, -100, 600, 600, 0, 0);
		add_point(-90, -40, 700, 300, 30, 0);
		add_point(-60, -120, 400, 800, 45, 0);
		add_point(64, 64, 300, 300, 120, 0);
		add_point(-33, 77, 900, 100, 200, 1);
		add_point(-70, -20, 650, 650, 300, 0);
		add_point(12, -99, 10, 1000, 89, 0);
		add_point(-99, 12, 1000, 10, 91, 0);
		add_point(50, 50, 200, 200, 271, 1);
		gaps_on = 1'b1;
		wait_drained();

		// a zero major axis, then the tally running into its cap
		set_pose_config(10'd0, 10'd1023, 7'd0, 7'd1);
		add_point(100, 100, 500, 500, 0, 0);
		add_point(-100, 80, 500, 500, 0, 1);
		wait_drained();
		set_pose_config(10'd1023, 10'd1023, 7'd127, 7'd1);
		for (k = 0; k < 45; k++)
			add_point($urandom_range(20, 127), $urandom_range(20, 127), 100, 100, 0, k == 44);
		wait_drained();

		for (ph = 0; ph < 7; ph++) begin
			gaps_on = (ph % 3 != 1);
			case (ph)
				0: set_pose_config(10'd1023, 10'd0, 7'd1, 7'd127);
				1: set_pose_config(10'd0, 10'd0, 7'd127, 7'd127);
				2: set_pose_config(10'd512, 10'd512, 7'd1, 7'd0);
				default: set_pose_config(pick_sensor(), pick_sensor(), pick_axis(), pick_axis());
			endcase
			add_poses(210);
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
